// ----- rtl/mpd_pkg.sv -----
// Shared types, constants and window helpers for the Manchester pulse decoder.
package mpd_pkg;

    // Configuration port and register widths
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 15;
    localparam int MARK_BITS      = 15;
    localparam int SPACE_BITS     = 14;
    localparam int HALF_BITS      = 14;
    localparam int TOL_BITS       = 6;

    // Register reset values
    localparam logic [MARK_BITS-1:0]  MARK_RESET  = '0;
    localparam logic [SPACE_BITS-1:0] SPACE_RESET = '0;
    localparam logic [HALF_BITS-1:0]  HALF_RESET  = HALF_BITS'(1);
    localparam logic [TOL_BITS-1:0]   TOL_RESET   = TOL_BITS'(25);

    // Window arithmetic: e * (100 +/- p), then floor divide by 100
    localparam int EXP_BITS    = 15;
    localparam int FACTOR_BITS = 8;
    localparam int PROD_BITS   = EXP_BITS + FACTOR_BITS;
    localparam int RECIP_BITS  = 24;
    localparam int RECIP_SHIFT = 30;
    localparam int QPROD_BITS  = PROD_BITS + RECIP_BITS;
    localparam logic [FACTOR_BITS-1:0] PCT_BASE = FACTOR_BITS'(100);
    // ceil(2^30 / 100): exact floor(x/100) for every x below 2^23
    localparam logic [RECIP_BITS-1:0]  RECIP_100 = RECIP_BITS'(10737419);

    // Bounds and durations are compared at 16 bits
    localparam int BOUND_BITS = 16;
    localparam int DUR_BITS   = 16;

    // Window table: two bounds per window, low bound at even step
    localparam int NUM_WIN     = 5;
    localparam int BOUND_STEPS = 2 * NUM_WIN;
    localparam int STEP_BITS   = $clog2(BOUND_STEPS);
    localparam int WIN_MARK       = 0;
    localparam int WIN_SPACE      = 1;
    localparam int WIN_SPACE_HALF = 2;
    localparam int WIN_HALF       = 3;
    localparam int WIN_DOUBLE     = 4;

    // Line levels of the two parts of a symbol
    localparam logic LVL_LOW  = 1'b0;
    localparam logic LVL_HIGH = 1'b1;

    typedef logic [EXP_BITS-1:0]    exp_t;
    typedef logic [FACTOR_BITS-1:0] factor_t;
    typedef logic [PROD_BITS-1:0]   prod_t;
    typedef logic [QPROD_BITS-1:0]  qprod_t;
    typedef logic [BOUND_BITS-1:0]  bound_t;
    typedef logic [DUR_BITS-1:0]    dur_t;
    typedef logic [STEP_BITS-1:0]   step_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MARK  = 2'd0,
        REG_SPACE = 2'd1,
        REG_HALF  = 2'd2,
        REG_TOL   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MARK  = 2'd1,
        ST_BAD_SPACE = 2'd2,
        ST_NO_DATA   = 2'd3
    } status_t;

    typedef struct packed {
        bound_t lo;
        bound_t hi;
    } window_t;

    // Precomputed windows handed from the bounds unit to the frame decoder
    typedef struct packed {
        window_t                 mark;
        window_t                 space;
        window_t                 space_half;
        window_t                 half;
        window_t                 dbl;
        logic                    hp_nz;
        logic [SPACE_BITS-1:0]   space_time;
    } bounds_t;

    // Outcome of classifying one data half
    typedef struct packed {
        logic ok;
        logic shift_en;
        logic pend_valid;
        logic pend_level;
    } half_res_t;

    function automatic logic in_win(input dur_t d, input window_t w);
        return (d >= w.lo) && (d <= w.hi);
    endfunction

    // Classify one half, then update the pending half; double window wins
    function automatic half_res_t half_step(
        input dur_t    d,
        input window_t dbl_w,
        input window_t half_w,
        input logic    hp_nz,
        input logic    pv,
        input logic    pl,
        input logic    level
    );
        logic      is_dbl;
        half_res_t r;
        is_dbl       = in_win(d, dbl_w);
        r.ok         = is_dbl || in_win(d, half_w);
        r.shift_en   = 1'b0;
        r.pend_valid = pv;
        r.pend_level = pl;
        if (r.ok)
        begin
            if (pv && (pl != level))
            begin
                r.shift_en   = 1'b1;
                r.pend_valid = is_dbl && hp_nz;
                if (is_dbl)
                begin
                    r.pend_level = level;
                end
            end
            else
            begin
                r.pend_level = level;
                r.pend_valid = hp_nz;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/mpd_bounds.sv -----
// Configuration registers and the sequencer that precomputes tolerance windows.
module mpd_bounds
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_fire,
    input  logic [mpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mpd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                busy,
    output mpd_pkg::bounds_t                    bounds
);

    logic [mpd_pkg::MARK_BITS-1:0]  mark_reg;
    logic [mpd_pkg::SPACE_BITS-1:0] space_reg;
    logic [mpd_pkg::HALF_BITS-1:0]  half_reg;
    logic [mpd_pkg::TOL_BITS-1:0]   tol_reg;

    logic                  run_reg;
    mpd_pkg::step_t        step_reg;
    mpd_pkg::prod_t        prod_reg;
    mpd_pkg::prod_t        prod_next;
    mpd_pkg::step_t        prod_idx_reg;
    logic                  prod_valid_reg;
    mpd_pkg::bound_t       bound_reg [mpd_pkg::BOUND_STEPS];

    mpd_pkg::exp_t         exp_sel;
    mpd_pkg::factor_t      factor_sel;
    mpd_pkg::qprod_t       qprod;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= mpd_pkg::MARK_RESET;
            space_reg <= mpd_pkg::SPACE_RESET;
            half_reg  <= mpd_pkg::HALF_RESET;
            tol_reg   <= mpd_pkg::TOL_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                mpd_pkg::REG_MARK:  mark_reg  <= cfg_data[mpd_pkg::MARK_BITS-1:0];
                mpd_pkg::REG_SPACE: space_reg <= cfg_data[mpd_pkg::SPACE_BITS-1:0];
                mpd_pkg::REG_HALF:  half_reg  <= cfg_data[mpd_pkg::HALF_BITS-1:0];
                mpd_pkg::REG_TOL:   tol_reg   <= cfg_data[mpd_pkg::TOL_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Pick the expected duration and percentage factor for this step
    always_comb
    begin
        case (step_reg[mpd_pkg::STEP_BITS-1:1])
            3'(mpd_pkg::WIN_MARK):       exp_sel = mark_reg;
            3'(mpd_pkg::WIN_SPACE):      exp_sel = mpd_pkg::exp_t'(space_reg);
            3'(mpd_pkg::WIN_SPACE_HALF): exp_sel = mpd_pkg::exp_t'(space_reg)
                                                 + mpd_pkg::exp_t'(half_reg);
            3'(mpd_pkg::WIN_HALF):       exp_sel = mpd_pkg::exp_t'(half_reg);
            3'(mpd_pkg::WIN_DOUBLE):     exp_sel = {half_reg, 1'b0};
            default:                     exp_sel = '0;
        endcase
        if (step_reg[0])
        begin
            factor_sel = mpd_pkg::PCT_BASE + mpd_pkg::factor_t'(tol_reg);
        end
        else
        begin
            factor_sel = mpd_pkg::PCT_BASE - mpd_pkg::factor_t'(tol_reg);
        end
    end

    assign prod_next = mpd_pkg::prod_t'(exp_sel) * mpd_pkg::prod_t'(factor_sel);

    // Divide the registered product by 100 through the reciprocal
    assign qprod = mpd_pkg::qprod_t'(prod_reg) * mpd_pkg::qprod_t'(mpd_pkg::RECIP_100);

    // Advance the step counter; restart on every register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= 1'b1;
            step_reg       <= '0;
            prod_valid_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            run_reg        <= 1'b1;
            step_reg       <= '0;
            prod_valid_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            prod_valid_reg <= 1'b1;
            if (step_reg == mpd_pkg::step_t'(mpd_pkg::BOUND_STEPS - 1))
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
        else
        begin
            prod_valid_reg <= 1'b0;
        end
    end

    // Hold the product and its step index
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            prod_reg     <= prod_next;
            prod_idx_reg <= step_reg;
        end
    end

    // Store the finished bound
    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            bound_reg[prod_idx_reg] <= qprod[mpd_pkg::RECIP_SHIFT +: mpd_pkg::BOUND_BITS];
        end
    end

    assign busy = run_reg || prod_valid_reg || cfg_fire;

    // Gather the bound table into windows
    always_comb
    begin
        bounds.mark.lo       = bound_reg[2 * mpd_pkg::WIN_MARK];
        bounds.mark.hi       = bound_reg[2 * mpd_pkg::WIN_MARK + 1];
        bounds.space.lo      = bound_reg[2 * mpd_pkg::WIN_SPACE];
        bounds.space.hi      = bound_reg[2 * mpd_pkg::WIN_SPACE + 1];
        bounds.space_half.lo = bound_reg[2 * mpd_pkg::WIN_SPACE_HALF];
        bounds.space_half.hi = bound_reg[2 * mpd_pkg::WIN_SPACE_HALF + 1];
        bounds.half.lo       = bound_reg[2 * mpd_pkg::WIN_HALF];
        bounds.half.hi       = bound_reg[2 * mpd_pkg::WIN_HALF + 1];
        bounds.dbl.lo        = bound_reg[2 * mpd_pkg::WIN_DOUBLE];
        bounds.dbl.hi        = bound_reg[2 * mpd_pkg::WIN_DOUBLE + 1];
        bounds.hp_nz         = (half_reg != '0);
        bounds.space_time    = space_reg;
    end

    // The mark and double windows are ordered once the table is settled
    a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (bounds.mark.lo <= bounds.mark.hi) && (bounds.dbl.lo <= bounds.dbl.hi))
        else $error("tolerance window out of order");

endmodule

// ----- rtl/mpd_frame.sv -----
// Frame state and per-symbol decode: header check, half classification, bit shift.
module mpd_frame
#(
    parameter int VALUE_BITS    = 64,
    parameter int DURATION_BITS = 15
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic                      frame_start,
    input  logic                      frame_last,
    input  logic [DURATION_BITS-1:0]  low_duration,
    input  logic [DURATION_BITS-1:0]  high_duration,
    input  logic                      high_level,
    input  mpd_pkg::bounds_t          bounds,
    output logic                      res_valid,
    output logic [VALUE_BITS-1:0]     res_value,
    output mpd_pkg::status_t          res_status
);

    mpd_pkg::phase_t         phase_reg;
    mpd_pkg::phase_t         phase_next;
    logic                    pv_reg;
    logic                    pv_next;
    logic                    pl_reg;
    logic                    pl_next;
    logic [VALUE_BITS-1:0]   shift_reg;
    logic [VALUE_BITS-1:0]   shift_next;
    logic                    acc_reg;
    logic                    acc_next;

    mpd_pkg::dur_t           d0;
    mpd_pkg::dur_t           d1;
    mpd_pkg::dur_t           space_d;
    mpd_pkg::dur_t           excess;
    logic                    mark_ok;
    logic                    space_ok;
    logic                    space_half_ok;
    logic                    half_fits;
    mpd_pkg::half_res_t      h0;
    mpd_pkg::half_res_t      h1;
    logic [VALUE_BITS-1:0]   sh0;
    logic [VALUE_BITS-1:0]   sh1;

    assign d0      = mpd_pkg::dur_t'(low_duration);
    assign d1      = mpd_pkg::dur_t'(high_duration);
    assign space_d = mpd_pkg::dur_t'(bounds.space_time);

    // Header checks
    assign mark_ok       = mpd_pkg::in_win(d0, bounds.mark);
    assign space_ok      = mpd_pkg::in_win(d1, bounds.space);
    assign space_half_ok = mpd_pkg::in_win(d1, bounds.space_half);
    assign excess        = (d1 >= space_d) ? (d1 - space_d) : '0;
    assign half_fits     = (d1 >= space_d) && mpd_pkg::in_win(excess, bounds.half);

    // Data halves: low part first, then high part against the updated pending half
    assign h0  = mpd_pkg::half_step(d0, bounds.dbl, bounds.half, bounds.hp_nz,
                                    pv_reg, pl_reg, mpd_pkg::LVL_LOW);
    assign h1  = mpd_pkg::half_step(d1, bounds.dbl, bounds.half, bounds.hp_nz,
                                    h0.pend_valid, h0.pend_level, mpd_pkg::LVL_HIGH);
    assign sh0 = h0.shift_en ? {shift_reg[VALUE_BITS-2:0], ~mpd_pkg::LVL_LOW} : shift_reg;
    assign sh1 = h1.shift_en ? {sh0[VALUE_BITS-2:0], ~mpd_pkg::LVL_HIGH} : sh0;

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mpd_pkg::PH_IDLE;
            pv_reg    <= 1'b0;
            pl_reg    <= mpd_pkg::LVL_LOW;
            shift_reg <= '0;
            acc_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pv_reg    <= pv_next;
            pl_reg    <= pl_next;
            shift_reg <= shift_next;
            acc_reg   <= acc_next;
        end
    end

    // Next state and result for the accepted symbol
    always_comb
    begin
        phase_next = phase_reg;
        pv_next    = pv_reg;
        pl_next    = pl_reg;
        shift_next = shift_reg;
        acc_next   = acc_reg;
        res_valid  = 1'b0;
        res_value  = '0;
        res_status = mpd_pkg::ST_OK;
        if (in_fire)
        begin
            if (frame_start)
            begin
                shift_next = '0;
                pv_next    = 1'b0;
                pl_next    = mpd_pkg::LVL_LOW;
                acc_next   = 1'b0;
                if (!mark_ok)
                begin
                    res_valid  = 1'b1;
                    res_status = mpd_pkg::ST_BAD_MARK;
                    phase_next = mpd_pkg::PH_DONE;
                end
                else if (!space_half_ok && !space_ok)
                begin
                    res_valid  = 1'b1;
                    res_status = mpd_pkg::ST_BAD_SPACE;
                    phase_next = mpd_pkg::PH_DONE;
                end
                else
                begin
                    // Space may carry one extra half that starts a pending half
                    if (space_half_ok && half_fits)
                    begin
                        pv_next = bounds.hp_nz;
                        pl_next = high_level;
                    end
                    phase_next = mpd_pkg::PH_DATA;
                    if (frame_last)
                    begin
                        res_valid  = 1'b1;
                        res_status = mpd_pkg::ST_NO_DATA;
                        phase_next = mpd_pkg::PH_DONE;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    mpd_pkg::PH_DATA:
                    begin
                        if (!h0.ok)
                        begin
                            res_valid  = 1'b1;
                            phase_next = mpd_pkg::PH_DONE;
                            res_value  = acc_reg ? shift_reg : '0;
                            res_status = acc_reg ? mpd_pkg::ST_OK : mpd_pkg::ST_NO_DATA;
                        end
                        else if (!h1.ok)
                        begin
                            // Keep the bit from the low half that passed
                            pv_next    = h0.pend_valid;
                            pl_next    = h0.pend_level;
                            shift_next = sh0;
                            res_valid  = 1'b1;
                            phase_next = mpd_pkg::PH_DONE;
                            res_value  = acc_reg ? sh0 : '0;
                            res_status = acc_reg ? mpd_pkg::ST_OK : mpd_pkg::ST_NO_DATA;
                        end
                        else
                        begin
                            pv_next    = h1.pend_valid;
                            pl_next    = h1.pend_level;
                            shift_next = sh1;
                            acc_next   = 1'b1;
                            if (frame_last)
                            begin
                                res_valid  = 1'b1;
                                phase_next = mpd_pkg::PH_DONE;
                                res_value  = sh1;
                                res_status = mpd_pkg::ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        // Drop symbols outside a frame
                    end
                endcase
            end
        end
    end

    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == mpd_pkg::PH_DONE))
        else $error("frame still open after its result");

    a_zero_on_failure: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_status != mpd_pkg::ST_OK)) |-> (res_value == '0))
        else $error("nonzero value with failure status");

endmodule

// ----- rtl/mpd_out_buf.sv -----
// Two-entry result buffer that decouples the decoder from the output handshake.
module mpd_out_buf
#(
    parameter int VALUE_BITS = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [VALUE_BITS-1:0]     push_value,
    input  mpd_pkg::status_t          push_status,
    output logic                      full,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [VALUE_BITS-1:0]     decoded_value,
    output logic [1:0]                frame_status
);

    logic [1:0]               count_reg;
    logic [VALUE_BITS-1:0]    head_value_reg;
    mpd_pkg::status_t         head_status_reg;
    logic [VALUE_BITS-1:0]    skid_value_reg;
    mpd_pkg::status_t         skid_status_reg;
    logic                     pop;

    assign pop = out_valid && out_ready;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // Load head and skid entries
    always_ff @(posedge clk)
    begin
        if (count_reg == 2'd2)
        begin
            if (pop)
            begin
                head_value_reg  <= skid_value_reg;
                head_status_reg <= skid_status_reg;
            end
        end
        else if (push)
        begin
            if ((count_reg == 2'd0) || pop)
            begin
                head_value_reg  <= push_value;
                head_status_reg <= push_status;
            end
            else
            begin
                skid_value_reg  <= push_value;
                skid_status_reg <= push_status;
            end
        end
    end

    assign full          = (count_reg == 2'd2);
    assign out_valid     = (count_reg != 2'd0);
    assign decoded_value = head_value_reg;
    assign frame_status  = head_status_reg;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("result beat pushed into full buffer");

endmodule

// ----- rtl/manchester_pulse_decoder.sv -----
// Top level of the Manchester pulse decoder: symbol in, decoded frame value out.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------------
//   in       | in_valid / in_ready   | frame_start, frame_last, low_duration,
//            |                       | high_duration, high_level
//   out      | out_valid / out_ready | decoded_value, frame_status
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One symbol per cycle while in_ready is high; the result beat of a frame is
// registered in the output buffer behind any result still held there. Tolerance
// windows come from a shared multiplier stepped over ten bounds: in_ready stays
// low after reset and after each register write until the bounds are settled.
// cfg_ready is always high. A two-entry output buffer keeps input moving while one
// result waits; the buffer holds in_ready low only when both entries are held.
module manchester_pulse_decoder
#(
    parameter int VALUE_BITS    = 64,
    parameter int DURATION_BITS = 15
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                frame_start,
    input  logic                                frame_last,
    input  logic [DURATION_BITS-1:0]            low_duration,
    input  logic [DURATION_BITS-1:0]            high_duration,
    input  logic                                high_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [VALUE_BITS-1:0]               decoded_value,
    output logic [1:0]                          frame_status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic                     cfg_fire;
    logic                     in_fire;
    logic                     bounds_busy;
    logic                     buf_full;
    mpd_pkg::bounds_t         bounds;
    logic                     res_valid;
    logic [VALUE_BITS-1:0]    res_value;
    mpd_pkg::status_t         res_status;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = !bounds_busy && !buf_full;
    assign in_fire   = in_valid && in_ready;

    mpd_bounds u_bounds
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (bounds_busy),
        .bounds    (bounds)
    );

    mpd_frame
    #(
        .VALUE_BITS    (VALUE_BITS),
        .DURATION_BITS (DURATION_BITS)
    )
    u_frame
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .frame_start   (frame_start),
        .frame_last    (frame_last),
        .low_duration  (low_duration),
        .high_duration (high_duration),
        .high_level    (high_level),
        .bounds        (bounds),
        .res_valid     (res_valid),
        .res_value     (res_value),
        .res_status    (res_status)
    );

    mpd_out_buf
    #(
        .VALUE_BITS (VALUE_BITS)
    )
    u_out_buf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (res_valid),
        .push_value    (res_value),
        .push_status   (res_status),
        .full          (buf_full),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .decoded_value (decoded_value),
        .frame_status  (frame_status)
    );

endmodule

// ----- bench/tb_manchester_pulse_decoder.sv -----
// Self-checking bench for the Manchester pulse decoder: frame stimulus, prediction, result check.
`timescale 1ns / 1ps

module tb_manchester_pulse_decoder;

    localparam int VAL_W           = 64;
    localparam int SYM_W           = 15;
    localparam int MAX_DUR         = (1 << SYM_W) - 1;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int ITEMS_PER_PHASE = 105;

    typedef logic [mpd_pkg::CFG_DATA_BITS-1:0] cfg_word_t;

    typedef enum {
        FRAME_CLEAN,
        FRAME_BAD_MARK,
        FRAME_BAD_SPACE,
        FRAME_BAD_DATA,
        FRAME_OPEN
    } frame_kind_t;

    typedef enum {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    typedef struct {
        logic [VAL_W-1:0] value;
        mpd_pkg::status_t status;
    } frame_result_t;

    // Decoder shadow: register copies, frame state and the queue of frame results owed
    class decode_scoreboard;
        logic [mpd_pkg::MARK_BITS-1:0]  mark_ticks  = mpd_pkg::MARK_RESET;
        logic [mpd_pkg::SPACE_BITS-1:0] space_ticks = mpd_pkg::SPACE_RESET;
        logic [mpd_pkg::HALF_BITS-1:0]  half_ticks  = mpd_pkg::HALF_RESET;
        logic [mpd_pkg::TOL_BITS-1:0]   tol_pct     = mpd_pkg::TOL_RESET;
        mpd_pkg::phase_t                stage       = mpd_pkg::PH_IDLE;
        bit                             half_pending;
        bit                             half_level;
        logic [VAL_W-1:0]               bits_in     = '0;
        bit                             had_symbol;
        frame_result_t                  expected_frames[$];
        int                             failures;

        function void set_reg(mpd_pkg::cfg_reg_t idx, cfg_word_t data);
            case (idx)
                mpd_pkg::REG_MARK:  mark_ticks  = data[mpd_pkg::MARK_BITS-1:0];
                mpd_pkg::REG_SPACE: space_ticks = data[mpd_pkg::SPACE_BITS-1:0];
                mpd_pkg::REG_HALF:  half_ticks  = data[mpd_pkg::HALF_BITS-1:0];
                mpd_pkg::REG_TOL:   tol_pct     = data[mpd_pkg::TOL_BITS-1:0];
                default:            ;
            endcase
        endfunction

        // Tolerance window test at full width
        function bit near(longint unsigned d, longint unsigned e);
            longint unsigned lo;
            longint unsigned hi;
            lo = (e * (64'd100 - tol_pct)) / 64'd100;
            hi = (e * (64'd100 + tol_pct)) / 64'd100;
            return (lo <= d) && (d <= hi);
        endfunction

        // Classify one data half and advance the pending half; 0 means invalid
        function bit absorb_half(longint unsigned d, bit level);
            longint unsigned hp;
            bit              dbl;
            hp  = 64'(half_ticks);
            dbl = near(d, 2 * hp);
            if (!dbl && !near(d, hp))
                return 1'b0;
            if (half_pending && (half_level != level))
            begin
                bits_in      = {bits_in[VAL_W-2:0], ~level};
                half_pending = dbl && (hp != 0);
                if (dbl)
                    half_level = level;
            end
            else
            begin
                half_level   = level;
                half_pending = (hp != 0);
            end
            return 1'b1;
        endfunction

        function void close_frame(logic [VAL_W-1:0] value, mpd_pkg::status_t st);
            frame_result_t r;
            r.value  = value;
            r.status = st;
            expected_frames.push_back(r);
            stage = mpd_pkg::PH_DONE;
        endfunction

        function void close_data();
            if (had_symbol)
                close_frame(bits_in, mpd_pkg::ST_OK);
            else
                close_frame('0, mpd_pkg::ST_NO_DATA);
        endfunction

        // Note one accepted symbol beat and queue the result it ends, if any
        function void note_symbol(bit start, bit last, logic [SYM_W-1:0] lo_d,
                                  logic [SYM_W-1:0] hi_d, bit lvl);
            longint unsigned space;
            longint unsigned hp;
            longint unsigned d1;
            space = 64'(space_ticks);
            hp    = 64'(half_ticks);
            d1    = 64'(hi_d);
            if (start)
            begin
                bits_in      = '0;
                half_pending = 1'b0;
                half_level   = 1'b0;
                had_symbol   = 1'b0;
                if (!near(64'(lo_d), 64'(mark_ticks)))
                begin
                    close_frame('0, mpd_pkg::ST_BAD_MARK);
                    return;
                end
                if (near(d1, space + hp))
                begin
                    if ((d1 >= space) && near(d1 - space, hp))
                    begin
                        half_pending = (hp != 0);
                        half_level   = lvl;
                    end
                end
                else if (!near(d1, space))
                begin
                    close_frame('0, mpd_pkg::ST_BAD_SPACE);
                    return;
                end
                stage = mpd_pkg::PH_DATA;
                if (last)
                    close_data();
                return;
            end
            if (stage != mpd_pkg::PH_DATA)
                return;
            if (!absorb_half(64'(lo_d), mpd_pkg::LVL_LOW) ||
                !absorb_half(64'(hi_d), mpd_pkg::LVL_HIGH))
            begin
                close_data();
                return;
            end
            had_symbol = 1'b1;
            if (last)
                close_data();
        endfunction

        // Compare one result beat with the oldest owed frame result
        function void check_result(logic [VAL_W-1:0] value, logic [1:0] status);
            frame_result_t want;
            if (expected_frames.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: value=%h status=%0d", value, status);
                return;
            end
            want = expected_frames.pop_front();
            if ((value !== want.value) || (status !== want.status))
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                             want.value, want.status, value, status);
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    logic                               frame_start;
    logic                               frame_last;
    logic [SYM_W-1:0]                   low_duration;
    logic [SYM_W-1:0]                   high_duration;
    logic                               high_level;
    logic                               out_valid;
    logic                               out_ready;
    logic [VAL_W-1:0]                   decoded_value;
    logic [1:0]                         frame_status;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [mpd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    cfg_word_t                          cfg_data;

    decode_scoreboard sb;
    int unsigned      cur_mark  = 32'(mpd_pkg::MARK_RESET);
    int unsigned      cur_space = 32'(mpd_pkg::SPACE_RESET);
    int unsigned      cur_half  = 32'(mpd_pkg::HALF_RESET);
    int unsigned      cur_tol   = 32'(mpd_pkg::TOL_RESET);
    int               burst_left;
    int               items_sent;
    int               cycle_count;
    bit               hold_req;

    manchester_pulse_decoder #(
        .VALUE_BITS    (VAL_W),
        .DURATION_BITS (SYM_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_start   (frame_start),
        .frame_last    (frame_last),
        .low_duration  (low_duration),
        .high_duration (high_duration),
        .high_level    (high_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .decoded_value (decoded_value),
        .frame_status  (frame_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Check every result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(decoded_value, frame_status);
    end

    // Drive out_ready: changing stall patterns, plus one long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       run_left;
        bit       hold_done;
        mode      = RX_OPEN;
        run_left  = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 3))
                        0:       mode = RX_OPEN;
                        1:       mode = RX_HALF;
                        2:       mode = RX_SPARSE;
                        default: mode = RX_TOGGLE;
                    endcase
                end
                run_left--;
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= !out_ready;
                endcase
            end
        end
    end

    function automatic int unsigned win_lo(int unsigned e);
        return (e * (100 - cur_tol)) / 100;
    endfunction

    function automatic int unsigned win_hi(int unsigned e);
        return (e * (100 + cur_tol)) / 100;
    endfunction

    // Random duration inside the window of e, edges favored
    function automatic logic [SYM_W-1:0] pick_near(int unsigned e);
        int unsigned lo;
        int unsigned hi;
        lo = win_lo(e);
        hi = win_hi(e);
        if (hi > MAX_DUR)
            hi = MAX_DUR;
        if (lo > hi)
            return SYM_W'(MAX_DUR);
        case ($urandom_range(0, 7))
            0:       return SYM_W'(lo);
            1:       return SYM_W'(hi);
            default: return SYM_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Random duration outside both windows where the range allows one
    function automatic logic [SYM_W-1:0] pick_far(int unsigned e1, int unsigned e2);
        int unsigned top;
        int unsigned bottom;
        int unsigned v;
        top    = (win_hi(e1) > win_hi(e2)) ? win_hi(e1) : win_hi(e2);
        bottom = (win_lo(e1) < win_lo(e2)) ? win_lo(e1) : win_lo(e2);
        if ((bottom > 0) && ((top >= MAX_DUR) || ($urandom_range(0, 2) == 0)))
            return SYM_W'($urandom_range(bottom - 1, 0));
        if (top < MAX_DUR)
        begin
            if ($urandom_range(0, 1))
                v = top + 1 + $urandom_range(0, 20);
            else
                v = $urandom_range(MAX_DUR, top + 1);
            return (v > MAX_DUR) ? SYM_W'(MAX_DUR) : SYM_W'(v);
        end
        return SYM_W'(MAX_DUR);
    endfunction

    function automatic logic [SYM_W-1:0] pick_half();
        return pick_near(cur_half * (($urandom_range(0, 9) < 4) ? 2 : 1));
    endfunction

    // Offer one symbol beat; open bursts and gaps at random
    task automatic send_symbol(input bit start, input bit last, input logic [SYM_W-1:0] lo_d,
                               input logic [SYM_W-1:0] hi_d, input bit lvl);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        frame_start   <= start;
        frame_last    <= last;
        low_duration  <= lo_d;
        high_duration <= hi_d;
        high_level    <= lvl;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_symbol(start, last, lo_d, hi_d, lvl);
        items_sent++;
    endtask

    // Drop valid, drain owed results, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers while idle; junk in the unused upper data bits
    task automatic apply_setting(input int unsigned mark, input int unsigned space,
                                 input int unsigned half, input int unsigned tol);
        mpd_pkg::cfg_reg_t regs[4];
        int unsigned       vals[4];
        int unsigned       widths[4];
        cfg_word_t         junk;
        regs   = '{mpd_pkg::REG_MARK, mpd_pkg::REG_SPACE, mpd_pkg::REG_HALF, mpd_pkg::REG_TOL};
        vals   = '{mark, space, half, tol};
        widths = '{mpd_pkg::MARK_BITS, mpd_pkg::SPACE_BITS, mpd_pkg::HALF_BITS,
                   mpd_pkg::TOL_BITS};
        settle();
        for (int i = 0; i < 4; i++)
        begin
            junk = cfg_word_t'($urandom);
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= cfg_word_t'((junk >> widths[i] << widths[i]) | vals[i]);
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(regs[i], cfg_data);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_mark  = 32'(sb.mark_ticks);
        cur_space = 32'(sb.space_ticks);
        cur_half  = 32'(sb.half_ticks);
        cur_tol   = 32'(sb.tol_pct);
    endtask

    // Random frames, mostly well formed, with some noise, until the item goal is met
    task automatic run_random(input int goal);
        frame_kind_t      kind;
        int               nsym;
        int               flaw_at;
        int               r;
        bit               last;
        logic [SYM_W-1:0] lo_d;
        logic [SYM_W-1:0] hi_d;
        while (items_sent < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                // noise beat, full field range
                send_symbol(($urandom_range(0, 9) == 0), 1'($urandom_range(0, 1)),
                            SYM_W'($urandom_range(MAX_DUR, 0)),
                            SYM_W'($urandom_range(MAX_DUR, 0)),
                            1'($urandom_range(0, 1)));
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                kind = FRAME_CLEAN;
            else if (r < 73)
                kind = FRAME_BAD_MARK;
            else if (r < 81)
                kind = FRAME_BAD_SPACE;
            else if (r < 93)
                kind = FRAME_BAD_DATA;
            else
                kind = FRAME_OPEN;
            r = $urandom_range(0, 99);
            if (r < 12)
                nsym = 0;
            else if (r < 97)
                nsym = $urandom_range(1, 6);
            else
                nsym = $urandom_range(20, 70);
            if ((kind == FRAME_BAD_DATA) && (nsym == 0))
                nsym = 1;
            flaw_at = (nsym > 0) ? $urandom_range(0, nsym - 1) : 0;

            // header beat
            lo_d = (kind == FRAME_BAD_MARK) ? pick_far(cur_mark, cur_mark) : pick_near(cur_mark);
            if (kind == FRAME_BAD_SPACE)
                hi_d = pick_far(cur_space, cur_space + cur_half);
            else if ($urandom_range(0, 1))
                hi_d = pick_near(cur_space + cur_half);
            else
                hi_d = pick_near(cur_space);
            send_symbol(1'b1, (nsym == 0) && (kind != FRAME_OPEN), lo_d, hi_d,
                        1'($urandom_range(0, 1)));

            // data beats; those after a frame error are ignored by the block
            for (int i = 0; i < nsym; i++)
            begin
                lo_d = pick_half();
                hi_d = pick_half();
                if ((kind == FRAME_BAD_DATA) && (i == flaw_at))
                begin
                    if ($urandom_range(0, 1))
                        hi_d = pick_far(cur_half, 2 * cur_half);
                    else
                        lo_d = pick_far(cur_half, 2 * cur_half);
                end
                last = (i == nsym - 1) && (kind != FRAME_OPEN);
                send_symbol(1'b0, last, lo_d, hi_d, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        frame_start   = 1'b0;
        frame_last    = 1'b0;
        low_duration  = '0;
        high_duration = '0;
        high_level    = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = mpd_pkg::REG_MARK;
        cfg_data      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values of the registers
        run_random(60);

        // Directed frames: mark 20, space 10, half 5, tolerance 25
        apply_setting(20, 10, 5, 25);
        send_symbol(1'b0, 1'b0, 5, 5, 1'b0);            // stray beat while idle
        send_symbol(1'b1, 1'b0, 40, 10, 1'b0);          // bad header mark
        send_symbol(1'b0, 1'b1, 5, 5, 1'b1);            // after frame end: ignored
        send_symbol(1'b1, 1'b0, 20, 40, 1'b0);          // bad header space
        send_symbol(1'b1, 1'b1, 20, 10, 1'b0);          // header only, no data
        send_symbol(1'b1, 1'b0, 20, 15, 1'b1);          // space plus half: pending high
        send_symbol(1'b0, 1'b0, 5, 5, 1'b0);
        send_symbol(1'b0, 1'b1, 10, 5, 1'b0);
        send_symbol(1'b1, 1'b0, 20, 10, 1'b0);          // frame dropped by a new start
        send_symbol(1'b0, 1'b0, 5, 10, 1'b0);
        send_symbol(1'b1, 1'b0, 20, 15, 1'b0);
        send_symbol(1'b0, 1'b1, 10, 10, 1'b1);
        send_symbol(1'b1, 1'b0, 20, 15, 1'b1);          // fail on a high half, keep partial bit
        send_symbol(1'b0, 1'b0, 5, 5, 1'b0);
        send_symbol(1'b0, 1'b1, 5, 40, 1'b0);
        send_symbol(1'b1, 1'b0, 20, 10, 1'b0);          // first data half invalid
        send_symbol(1'b0, 1'b0, 40, 5, 1'b0);
        send_symbol(1'b1, 1'b1, SYM_W'(MAX_DUR), SYM_W'(MAX_DUR), 1'b1); // widest durations
        send_symbol(1'b1, 1'b0, 0, 0, 1'b0);            // zero durations
        run_random(items_sent + ITEMS_PER_PHASE);

        // Largest register values, zero tolerance
        apply_setting(32767, 16383, 16383, 0);
        run_random(items_sent + ITEMS_PER_PHASE);

        // Zero half period collapses the data windows
        apply_setting(1000, 500, 0, 50);
        run_random(items_sent + ITEMS_PER_PHASE);

        // Tolerance above 50
        apply_setting(300, 150, 100, 63);
        run_random(items_sent + ITEMS_PER_PHASE);

        // Smallest timings, zero tolerance
        apply_setting(0, 0, 1, 0);
        run_random(items_sent + ITEMS_PER_PHASE);

        // Hold off the result side long enough to back up the input
        apply_setting(8000, 4000, 1000, 10);
        hold_req = 1'b1;
        run_random(items_sent + ITEMS_PER_PHASE);

        settle();
        if ((sb.failures == 0) && (sb.expected_frames.size() == 0))
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mpd_pkg.sv
rtl/mpd_bounds.sv
rtl/mpd_frame.sv
rtl/mpd_out_buf.sv
rtl/manchester_pulse_decoder.sv
bench/tb_manchester_pulse_decoder.sv
